>>> rtl/sitl_pkg.sv
`default_nettype none
package sitl_pkg;

	localparam int DEF_TABLE_CAPACITY = 64;
	localparam int DEF_ID_BITS = 16;

	localparam int IN_ID_W = 17;
	localparam int STATUS_W = 3;
	localparam int SLOT_W = 7;

	localparam logic [STATUS_W-1:0] ST_HIT = 3'd0;
	localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd1;
	localparam logic [STATUS_W-1:0] ST_ABSENT = 3'd2;
	localparam logic [STATUS_W-1:0] ST_INVALID = 3'd3;
	localparam logic [STATUS_W-1:0] ST_FULL = 3'd4;

	typedef struct packed {
		logic lt;
		logic eq;
		logic gt;
	} cmp_res_t;

endpackage
`default_nettype wire

>>> rtl/sitl_cmp.sv
`default_nettype none
module sitl_cmp #(
	parameter int WIDTH = 16
) (
	input  wire logic [WIDTH-1:0] a,
	input  wire logic [WIDTH-1:0] b,
	output sitl_pkg::cmp_res_t    res
);
	import sitl_pkg::*;

	// shared magnitude compare, a against b
	always_comb begin
		res.lt = (a < b);
		res.eq = (a == b);
		res.gt = (a > b);
	end

endmodule
`default_nettype wire

>>> rtl/sitl_store.sv
`default_nettype none
module sitl_store #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

>>> rtl/sitl_ctrl.sv
`default_nettype none
module sitl_ctrl #(
	parameter int TABLE_CAPACITY = 64,
	parameter int ID_BITS = 16,
	localparam int AW = (TABLE_CAPACITY > 1) ? $clog2(TABLE_CAPACITY) : 1
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              start,
	output logic                                   busy,
	input  wire logic                              func,
	input  wire logic signed [sitl_pkg::IN_ID_W-1:0] image_id,
	output logic                                   done,
	output logic [sitl_pkg::STATUS_W-1:0]          status,
	output logic [sitl_pkg::SLOT_W-1:0]            slot,
	output logic [sitl_pkg::SLOT_W-1:0]            entry_total,
	output logic                                   mem_we,
	output logic [AW-1:0]                          mem_waddr,
	output logic [ID_BITS-1:0]                     mem_wdata,
	output logic                                   mem_re,
	output logic [AW-1:0]                          mem_raddr,
	input  wire logic [ID_BITS-1:0]                mem_rdata
);
	import sitl_pkg::*;

	localparam int CNT_W = $clog2(TABLE_CAPACITY + 1);
	localparam int CMP_W = (ID_BITS > CNT_W) ? ID_BITS : CNT_W;
	localparam logic [CNT_W-1:0] CAP = CNT_W'(TABLE_CAPACITY);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_PRE   = 4'd1;
	localparam logic [3:0] S_LOOK  = 4'd2;
	localparam logic [3:0] S_CMP   = 4'd3;
	localparam logic [3:0] S_SHIFT = 4'd4;
	localparam logic [3:0] S_INS   = 4'd5;
	localparam logic [3:0] S_DP    = 4'd6;
	localparam logic [3:0] S_DPC   = 4'd7;

	logic [3:0]         state_q;
	logic               func_q;
	logic [ID_BITS-1:0] id_q;
	logic [CNT_W-1:0]   lo_q, hi_q, mid_q, idx_q, dp_q, cnt_q;

	logic [IN_ID_W-1:0] raw;
	logic               id_ok, accept;
	logic [CNT_W:0]     mid_sum;
	logic [CNT_W-1:0]   mid, cnt_m1, idx_m1, idx_m2;
	logic               range_open, ins_ok;
	logic [CMP_W-1:0]   op_a, op_b;
	cmp_res_t           cmp;

	logic               emit;
	logic [STATUS_W-1:0] emit_status;
	logic [SLOT_W-1:0]  emit_slot;

	assign raw = image_id;
	assign id_ok = !raw[IN_ID_W-1] && ((raw >> ID_BITS) == '0);
	assign accept = start && (state_q == S_IDLE);
	assign busy = (state_q != S_IDLE);

	assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid = mid_sum[CNT_W:1];
	assign cnt_m1 = cnt_q - 1'b1;
	assign idx_m1 = idx_q - 1'b1;
	assign idx_m2 = idx_q - CNT_W'(2);
	assign range_open = (lo_q < hi_q);
	assign ins_ok = func_q && (cnt_q != CAP);

	always_comb begin
		unique case (state_q)
			S_PRE: begin
				op_a = CMP_W'(id_q);
				op_b = CMP_W'(dp_q);
			end
			S_DPC: begin
				op_a = CMP_W'(mem_rdata);
				op_b = CMP_W'(dp_q);
			end
			default: begin
				op_a = CMP_W'(id_q);
				op_b = CMP_W'(mem_rdata);
			end
		endcase
	end

	sitl_cmp #(
		.WIDTH(CMP_W)
	) u_cmp (
		.a  (op_a),
		.b  (op_b),
		.res(cmp)
	);

	always_comb begin
		mem_we = 1'b0;
		mem_waddr = lo_q[AW-1:0];
		mem_wdata = id_q;
		mem_re = 1'b0;
		mem_raddr = mid[AW-1:0];
		emit = 1'b0;
		emit_status = ST_HIT;
		emit_slot = SLOT_W'(lo_q);
		unique case (state_q)
			S_IDLE: begin
				if (accept && !id_ok) begin
					emit = 1'b1;
					emit_status = ST_INVALID;
					emit_slot = '0;
				end
			end
			S_PRE: begin
				if (cmp.lt) begin
					emit = 1'b1;
					emit_slot = SLOT_W'(id_q);
				end
			end
			S_LOOK: begin
				if (range_open) begin
					mem_re = 1'b1;
				end else if (!func_q) begin
					emit = 1'b1;
					emit_status = ST_ABSENT;
				end else if (cnt_q == CAP) begin
					emit = 1'b1;
					emit_status = ST_FULL;
				end else if (cnt_q > lo_q) begin
					mem_re = 1'b1;
					mem_raddr = cnt_m1[AW-1:0];
				end
			end
			S_CMP: begin
				if (cmp.eq) begin
					emit = 1'b1;
					emit_slot = SLOT_W'(mid_q);
				end
			end
			S_SHIFT: begin
				mem_we = 1'b1;
				mem_waddr = idx_q[AW-1:0];
				mem_wdata = mem_rdata;
				if (idx_m1 > lo_q) begin
					mem_re = 1'b1;
					mem_raddr = idx_m2[AW-1:0];
				end
			end
			S_INS: begin
				mem_we = 1'b1;
			end
			S_DP: begin
				if (dp_q < cnt_q) begin
					mem_re = 1'b1;
					mem_raddr = dp_q[AW-1:0];
				end else begin
					emit = 1'b1;
					emit_status = ST_INSERTED;
				end
			end
			S_DPC: begin
				if (!cmp.eq) begin
					emit = 1'b1;
					emit_status = ST_INSERTED;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
			dp_q <= '0;
			done <= 1'b0;
		end else begin
			done <= emit;
			unique case (state_q)
				S_IDLE: begin
					if (accept && id_ok) begin
						state_q <= S_PRE;
					end
				end
				S_PRE: begin
					state_q <= cmp.lt ? S_IDLE : S_LOOK;
				end
				S_LOOK: begin
					if (range_open) begin
						state_q <= S_CMP;
					end else if (!ins_ok) begin
						state_q <= S_IDLE;
					end else if (cnt_q > lo_q) begin
						state_q <= S_SHIFT;
					end else begin
						state_q <= S_INS;
					end
				end
				S_CMP: begin
					state_q <= cmp.eq ? S_IDLE : S_LOOK;
				end
				S_SHIFT: begin
					if (!(idx_m1 > lo_q)) begin
						state_q <= S_INS;
					end
				end
				S_INS: begin
					cnt_q <= cnt_q + 1'b1;
					state_q <= S_DP;
				end
				S_DP: begin
					state_q <= (dp_q < cnt_q) ? S_DPC : S_IDLE;
				end
				S_DPC: begin
					if (cmp.eq) begin
						dp_q <= dp_q + 1'b1;
						state_q <= S_DP;
					end else begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_q <= func;
			id_q <= ID_BITS'(raw[IN_ID_W-2:0]);
			lo_q <= dp_q;
			hi_q <= cnt_q;
		end
		if (state_q == S_LOOK) begin
			mid_q <= mid;
			idx_q <= cnt_q;
		end
		if (state_q == S_CMP) begin
			if (cmp.lt) begin
				hi_q <= mid_q;
			end else if (cmp.gt) begin
				lo_q <= mid_q + 1'b1;
			end
		end
		if (state_q == S_SHIFT) begin
			idx_q <= idx_m1;
		end
		if (emit) begin
			status <= emit_status;
			slot <= emit_slot;
			entry_total <= SLOT_W'(cnt_q);
		end
	end

	a_dp_le_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		dp_q <= cnt_q)
		else $error("dense prefix beyond entry count");

	a_cnt_le_cap: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CAP)
		else $error("entry count beyond capacity");

	a_shift_above_lo: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SHIFT) |-> (idx_q > lo_q))
		else $error("shift ran below insertion point");

	a_ins_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_INS) |=> (cnt_q == $past(cnt_q) + 1'b1))
		else $error("insert did not grow the table");

	a_port_clash: assert property (@(posedge clk) disable iff (!arst_n)
		(mem_we && mem_re) |-> (mem_waddr != mem_raddr))
		else $error("read and write at one address");

endmodule
`default_nettype wire

>>> rtl/sorted_id_table_lookup_insert.sv
// Sorted id table with lookup and insert on miss. Pulse start while busy is low to
// issue one item; its single result appears on status, slot and entry_total for exactly one
// cycle with done high, and the receiver cannot hold it off. The search is paced by the one
// compare unit and the one read port of the table, one probe at a time: an invalid id is
// answered from idle, an id inside the dense prefix after one compare, and a search that
// hits or misses after a binary search of up to log2(capacity) + 1 probes. An insert
// shifts up each entry above the insertion point, writes the new id, then grows the dense
// prefix one step at a time while the entry at its end equals its index. The table needs no
// clearing after reset.
`default_nettype none
module sorted_id_table_lookup_insert #(
	parameter int TABLE_CAPACITY = sitl_pkg::DEF_TABLE_CAPACITY,
	parameter int ID_BITS = sitl_pkg::DEF_ID_BITS
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                start,
	output logic                                     busy,
	input  wire logic                                func,
	input  wire logic signed [sitl_pkg::IN_ID_W-1:0] image_id,
	output logic                                     done,
	output logic [sitl_pkg::STATUS_W-1:0]            status,
	output logic [sitl_pkg::SLOT_W-1:0]              slot,
	output logic [sitl_pkg::SLOT_W-1:0]              entry_total
);
	import sitl_pkg::*;

	localparam int AW = (TABLE_CAPACITY > 1) ? $clog2(TABLE_CAPACITY) : 1;

	logic               mem_we, mem_re;
	logic [AW-1:0]      mem_waddr, mem_raddr;
	logic [ID_BITS-1:0] mem_wdata, mem_rdata;

	sitl_ctrl #(
		.TABLE_CAPACITY(TABLE_CAPACITY),
		.ID_BITS       (ID_BITS)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.func       (func),
		.image_id   (image_id),
		.done       (done),
		.status     (status),
		.slot       (slot),
		.entry_total(entry_total),
		.mem_we     (mem_we),
		.mem_waddr  (mem_waddr),
		.mem_wdata  (mem_wdata),
		.mem_re     (mem_re),
		.mem_raddr  (mem_raddr),
		.mem_rdata  (mem_rdata)
	);

	sitl_store #(
		.DEPTH(TABLE_CAPACITY),
		.WIDTH(ID_BITS)
	) u_store (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

endmodule
`default_nettype wire
